FILE: rtl/ptnp_pkg.sv
// Shared types and constants for the primality test and next-prime unit.
package ptnp_pkg;

  localparam int VALUE_BITS    = 64;
  localparam int WORD_BITS_DEF = 64;

  // Trial division constants: odd divisor three, first 6k-1 divisor and its square,
  // then alternating steps of two and four.
  localparam int DIV_THREE  = 3;
  localparam int FIRST_DIV  = 5;
  localparam int FIRST_SQ   = 25;
  localparam int STEP_SHORT = 2;
  localparam int STEP_LONG  = 4;
  localparam int SQ_SHORT   = 4;
  localparam int SQ_LONG    = 16;
  localparam int SMALLEST_PRIME = 2;

  typedef enum logic {
    ACT_TEST = 1'b0,
    ACT_NEXT = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAND,
    ST_DIV3,
    ST_CHECK,
    ST_DIVW,
    ST_STEP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } rem_stat_t;

endpackage

FILE: rtl/ptnp_if.sv
// Request and result channel interfaces of the primality unit.
interface ptnp_req_if import ptnp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface ptnp_rsp_if import ptnp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  is_prime;
  logic [VALUE_BITS-1:0] next_prime;
  logic                  no_fit;

  modport source (output valid, output is_prime, output next_prime, output no_fit,
                  input ready);
  modport sink   (input valid, input is_prime, input next_prime, input no_fit,
                  output ready);
endinterface

FILE: rtl/prime_test_and_next_prime_u64_unit.sv
// Top level: primality test and next-prime search by 6k+-1 trial division.
//
// Channels: req_i carries a request (action, value); rsp_o returns exactly one
// result (is_prime, next_prime, no_fit) per request, in order, valid/ready.
// A test request (action 0) answers is_prime; a next request (action 1)
// answers the smallest prime above value, or no_fit when none fits in
// WORD_BITS bits. Only the low WORD_BITS bits of value are used.
// Work: a candidate n is first divided by three, then by one trial divisor
// after another, up to about sqrt(n)/3 divisors; a next request adds that up
// over every odd candidate it visits. Values below two and even values finish
// without a division. Each division runs in the serial remainder unit, which
// retires one dividend bit per cycle.
// One request is worked on at a time; req_i.ready is high only when idle.
// Reset: the unit comes up idle with an empty result register.
// Stall: a finished result waits in the output register; the next request is
// still taken, and its result waits in the working registers until the
// output register is free.
module prime_test_and_next_prime_u64_unit import ptnp_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  ptnp_req_if.sink   req_i,
  ptnp_rsp_if.source rsp_o
);

  localparam int SQW = WORD_BITS + 1;
  localparam logic [WORD_BITS-1:0] MASK = '1;

  state_e                state_q, state_d;
  action_e               action_q, action_d;
  logic [WORD_BITS-1:0]  cand_q, cand_d;
  logic [WORD_BITS-1:0]  dv_q, dv_d;
  logic [SQW-1:0]        sq_q, sq_d;
  logic                  inc4_q, inc4_d;
  logic                  res_prime_q, res_prime_d;
  logic [WORD_BITS-1:0]  res_next_q, res_next_d;
  logic                  res_nofit_q, res_nofit_d;
  logic                  out_vld_q, out_vld_d;
  logic                  out_prime_q;
  logic [WORD_BITS-1:0]  out_next_q;
  logic                  out_nofit_q;
  logic                  out_load;
  logic                  verdict;
  logic                  verdict_prime;
  logic                  div_start;
  logic [WORD_BITS-1:0]  div_dvs;
  logic [WORD_BITS-1:0]  v_in;
  rem_stat_t             div_stat;

  assign v_in = req_i.value[WORD_BITS-1:0];

  ptnp_rem #(.WORD_BITS(WORD_BITS)) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cand_q),
    .divisor_i  (div_dvs),
    .stat_o     (div_stat)
  );

  always_comb begin
    state_d       = state_q;
    action_d      = action_q;
    cand_d        = cand_q;
    dv_d          = dv_q;
    sq_d          = sq_q;
    inc4_d        = inc4_q;
    res_prime_d   = res_prime_q;
    res_next_d    = res_next_q;
    res_nofit_d   = res_nofit_q;
    verdict       = 1'b0;
    verdict_prime = 1'b0;
    div_start     = 1'b0;
    div_dvs       = dv_q;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          action_d    = action_e'(req_i.action);
          res_prime_d = 1'b0;
          res_next_d  = '0;
          res_nofit_d = 1'b0;
          if (action_e'(req_i.action) == ACT_TEST) begin
            cand_d  = v_in;
            state_d = ST_CAND;
          end else if (v_in < WORD_BITS'(SMALLEST_PRIME)) begin
            res_next_d = WORD_BITS'(SMALLEST_PRIME);
            state_d    = ST_DONE;
          end else if (v_in == MASK) begin
            res_nofit_d = 1'b1;
            state_d     = ST_DONE;
          end else begin
            // first odd value above the request; the mask is odd so this fits
            cand_d  = (v_in + WORD_BITS'(1)) | WORD_BITS'(1);
            state_d = ST_CAND;
          end
        end
      end
      ST_CAND: begin
        if (cand_q < WORD_BITS'(SMALLEST_PRIME)) begin
          verdict = 1'b1;
        end else if (!cand_q[0]) begin
          verdict       = 1'b1;
          verdict_prime = (cand_q == WORD_BITS'(SMALLEST_PRIME));
        end else begin
          div_start = 1'b1;
          div_dvs   = WORD_BITS'(DIV_THREE);
          state_d   = ST_DIV3;
        end
      end
      ST_DIV3: begin
        if (div_stat.done) begin
          if (div_stat.zero) begin
            verdict       = 1'b1;
            verdict_prime = (cand_q == WORD_BITS'(DIV_THREE));
          end else begin
            dv_d    = WORD_BITS'(FIRST_DIV);
            sq_d    = SQW'(FIRST_SQ);
            inc4_d  = 1'b0;
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sq_q > {1'b0, cand_q}) begin
          verdict       = 1'b1;
          verdict_prime = 1'b1;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIVW;
        end
      end
      ST_DIVW: begin
        if (div_stat.done) begin
          if (div_stat.zero) begin
            verdict = 1'b1;
          end else begin
            state_d = ST_STEP;
          end
        end
      end
      ST_STEP: begin
        // advance to the next 6k+-1 divisor and its square: (d+i)^2 = d^2 + 2id + i^2
        if (inc4_q) begin
          dv_d = dv_q + WORD_BITS'(STEP_LONG);
          sq_d = sq_q + ({1'b0, dv_q} << 3) + SQW'(SQ_LONG);
        end else begin
          dv_d = dv_q + WORD_BITS'(STEP_SHORT);
          sq_d = sq_q + ({1'b0, dv_q} << 2) + SQW'(SQ_SHORT);
        end
        inc4_d  = !inc4_q;
        state_d = ST_CHECK;
      end
      ST_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (verdict) begin
      if (action_q == ACT_TEST) begin
        res_prime_d = verdict_prime;
        state_d     = ST_DONE;
      end else if (verdict_prime) begin
        res_next_d = cand_q;
        state_d    = ST_DONE;
      end else if (cand_q > MASK - WORD_BITS'(STEP_SHORT)) begin
        res_nofit_d = 1'b1;
        state_d     = ST_DONE;
      end else begin
        cand_d  = cand_q + WORD_BITS'(STEP_SHORT);
        state_d = ST_CAND;
      end
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q    <= action_d;
    cand_q      <= cand_d;
    dv_q        <= dv_d;
    sq_q        <= sq_d;
    inc4_q      <= inc4_d;
    res_prime_q <= res_prime_d;
    res_next_q  <= res_next_d;
    res_nofit_q <= res_nofit_d;
    if (out_load) begin
      out_prime_q <= res_prime_q;
      out_next_q  <= res_next_q;
      out_nofit_q <= res_nofit_q;
    end
  end

  assign req_i.ready      = (state_q == ST_IDLE);
  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.is_prime   = out_prime_q;
  assign rsp_o.next_prime = VALUE_BITS'(out_next_q);
  assign rsp_o.no_fit     = out_nofit_q;

  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !div_stat.busy)
    else $error("remainder unit busy while idle");
  a_check_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHECK |-> cand_q[0] && sq_q[0] && dv_q[0])
    else $error("even candidate or divisor in trial loop");
  a_nofit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_nofit_q |-> out_next_q == '0 && !out_prime_q)
    else $error("no-fit result carries a value");
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && out_vld_q && !rsp_o.ready |=> state_q == ST_DONE)
    else $error("result overwrote a stalled output");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_vld_q || rsp_o.ready)
    else $error("output register loaded while occupied");

endmodule

FILE: rtl/ptnp_rem.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module ptnp_rem import ptnp_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [WORD_BITS-1:0] dividend_i,
  input  logic [WORD_BITS-1:0] divisor_i,
  output rem_stat_t            stat_o
);

  localparam int CW = $clog2(WORD_BITS);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [WORD_BITS-1:0] sh_q, sh_d;
  logic [WORD_BITS-1:0] rem_q, rem_d;
  logic [WORD_BITS-1:0] dvs_q, dvs_d;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS:0]   diff;

  assign trial = {rem_q, sh_q[WORD_BITS-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      sh_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // keep the partial remainder when the trial subtraction goes negative
      rem_d = diff[WORD_BITS] ? trial[WORD_BITS-1:0] : diff[WORD_BITS-1:0];
      sh_d  = {sh_q[WORD_BITS-2:0], 1'b0};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(WORD_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign stat_o.zero = (rem_q == '0);

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("remainder unit restarted while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("remainder done without a preceding run");
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < dvs_q))
    else $error("remainder not below divisor");

endmodule
